/* hw/rtl/motor_arm_and_throttle_ramp_assert.svh */
// Assertion macros used by the checker file of the motor arm and throttle ramp block.
`ifndef MOTOR_ARM_AND_THROTTLE_RAMP_ASSERT_SVH
`define MOTOR_ARM_AND_THROTTLE_RAMP_ASSERT_SVH

// same-cycle implication
`define MAT_ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("mat assertion failed");

// next-cycle implication
`define MAT_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("mat assertion failed");

`endif

/* hw/rtl/mat_pkg.sv */
// Package: types, widths and constants of the motor arm and throttle ramp block.
`timescale 1ns / 1ps
package mat_pkg;

	localparam int FRAC_BITS = 16;

	localparam int PULSE_W  = 12;
	localparam int ALT_W    = 21;
	localparam int TIME_W   = 32;
	localparam int STEP_W   = 24;
	localparam int DT_W     = 16;
	localparam int MODE_W   = 2;
	localparam int THR_W    = PULSE_W + FRAC_BITS;
	localparam int PROD_W   = STEP_W + DT_W;
	localparam int SUM_W    = ((PROD_W > THR_W) ? PROD_W : THR_W) + 1;

	localparam int APB_DW   = 32;
	localparam int APB_AW   = 5;
	localparam int REG_IDX_W = 3;

	// register indexes (byte address / 4)
	localparam logic [REG_IDX_W-1:0] REG_PULSE_OFF = 3'd0;
	localparam logic [REG_IDX_W-1:0] REG_PULSE_RUN = 3'd1;
	localparam logic [REG_IDX_W-1:0] REG_ALT_TRIG  = 3'd2;
	localparam logic [REG_IDX_W-1:0] REG_RAMP_STEP = 3'd3;
	localparam logic [REG_IDX_W-1:0] REG_MAX_DT    = 3'd4;

	// reset values
	localparam logic [PULSE_W-1:0] PULSE_OFF_RST = 12'd1000;
	localparam logic [PULSE_W-1:0] PULSE_RUN_RST = 12'd2000;
	localparam logic [ALT_W-1:0]   ALT_TRIG_RST  = 21'd5000;
	localparam logic [STEP_W-1:0]  RAMP_STEP_RST = 24'd131072;
	localparam logic [DT_W-1:0]    MAX_DT_RST    = 16'd100;

	typedef enum logic [MODE_W-1:0] {
		MODE_DISARMED  = 2'd0,
		MODE_ARMED     = 2'd1,
		MODE_MOTORS_ON = 2'd2
	} mode_t;

	typedef struct packed {
		logic [PULSE_W-1:0] pulse_off_us;
		logic [PULSE_W-1:0] pulse_run_us;
		logic [ALT_W-1:0]   alt_trigger_dm;
		logic [STEP_W-1:0]  ramp_step_q16;
		logic [DT_W-1:0]    max_dt_ms;
	} cfg_t;

endpackage

/* hw/rtl/mat_if.sv */
// Interfaces: control tick input channel and result output channel.
`timescale 1ns / 1ps
interface mat_tick_if import mat_pkg::*; ();
	logic                     valid;
	logic                     ready;
	logic                     arm_request;
	logic                     attitude_level;
	logic                     is_descending;
	logic signed [ALT_W-1:0]  altitude_dm;
	logic        [TIME_W-1:0] time_ms;

	modport source (output valid, arm_request, attitude_level, is_descending, altitude_dm,
		time_ms, input ready);
	modport sink (input valid, arm_request, attitude_level, is_descending, altitude_dm,
		time_ms, output ready);
endinterface

interface mat_result_if import mat_pkg::*; ();
	logic               valid;
	logic               ready;
	logic [PULSE_W-1:0] pulse_us;
	logic [MODE_W-1:0]  mode;

	modport source (output valid, pulse_us, mode, input ready);
	modport sink (input valid, pulse_us, mode, output ready);
endinterface

/* hw/rtl/mat_cfg_regs.sv */
// APB-style configuration register file of the motor arm and throttle ramp block.
`timescale 1ns / 1ps
module mat_cfg_regs import mat_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [APB_AW-1:0] paddr,
	input  logic [APB_DW-1:0] pwdata,
	output logic [APB_DW-1:0] prdata,
	output logic              pready,
	output cfg_t              cfg
);

	cfg_t                 cfg_q;
	logic                 wr_en;
	logic [REG_IDX_W-1:0] idx;

	assign pready = 1'b1;
	assign idx    = paddr[APB_AW-1:2];
	assign wr_en  = psel && penable && pwrite && pready;
	assign cfg    = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.pulse_off_us   <= PULSE_OFF_RST;
			cfg_q.pulse_run_us   <= PULSE_RUN_RST;
			cfg_q.alt_trigger_dm <= ALT_TRIG_RST;
			cfg_q.ramp_step_q16  <= RAMP_STEP_RST;
			cfg_q.max_dt_ms      <= MAX_DT_RST;
		end else if (wr_en) begin
			case (idx)
				REG_PULSE_OFF: cfg_q.pulse_off_us   <= pwdata[PULSE_W-1:0];
				REG_PULSE_RUN: cfg_q.pulse_run_us   <= pwdata[PULSE_W-1:0];
				REG_ALT_TRIG:  cfg_q.alt_trigger_dm <= pwdata[ALT_W-1:0];
				REG_RAMP_STEP: cfg_q.ramp_step_q16  <= pwdata[STEP_W-1:0];
				REG_MAX_DT:    cfg_q.max_dt_ms      <= pwdata[DT_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (idx)
			REG_PULSE_OFF: prdata = {{(APB_DW-PULSE_W){1'b0}}, cfg_q.pulse_off_us};
			REG_PULSE_RUN: prdata = {{(APB_DW-PULSE_W){1'b0}}, cfg_q.pulse_run_us};
			REG_ALT_TRIG:  prdata = {{(APB_DW-ALT_W){cfg_q.alt_trigger_dm[ALT_W-1]}},
				cfg_q.alt_trigger_dm};
			REG_RAMP_STEP: prdata = {{(APB_DW-STEP_W){1'b0}}, cfg_q.ramp_step_q16};
			REG_MAX_DT:    prdata = {{(APB_DW-DT_W){1'b0}}, cfg_q.max_dt_ms};
			default:       prdata = '0;
		endcase
	end

endmodule

/* hw/rtl/motor_arm_and_throttle_ramp.sv */
// Top level: motor arm state machine and fixed-point throttle ramp.
`timescale 1ns / 1ps
// One control tick per transaction on tick, one result transaction on result per tick, in
// order. Throughput is one tick per clock while the result is not stalled; an accepted tick
// is held in stage one and moves on to the output register once that is free. Stage
// one, at acceptance, forms the clamped elapsed time against the stored
// stamp; the commit stage does the 24x16 step-times-elapsed multiply, the add to the
// throttle and the saturation compare against the run pulse, and updates mode and throttle.
// Throttle is Q(12.FRAC_BITS) microseconds; pulse_us is its integer part. A stalled result
// holds in the output register while one more tick waits in stage one. Registers are at
// byte addresses 0 (off pulse), 4 (run pulse), 8 (trigger altitude, signed), 12 (ramp step)
// and 16 (elapsed clamp); write them only while no tick is in flight. No clearing pass.
module motor_arm_and_throttle_ramp import mat_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	mat_tick_if.sink          tick,
	mat_result_if.source      result,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [APB_AW-1:0] paddr,
	input  logic [APB_DW-1:0] pwdata,
	output logic [APB_DW-1:0] prdata,
	output logic              pready
);

	cfg_t cfg;

	mat_cfg_regs u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	// ---- stage one: capture tick, elapsed time ----
	logic              accept;
	logic              advance;
	logic [TIME_W-1:0] last_time_q;
	logic [TIME_W-1:0] diff;
	logic [DT_W-1:0]   dt;

	logic              valid_s1;
	logic              arm_s1;
	logic              level_s1;
	logic              desc_s1;
	logic [ALT_W-1:0]  alt_s1;
	logic [DT_W-1:0]   dt_s1;

	assign accept     = tick.valid && tick.ready;
	assign advance    = valid_s1 && (!result.valid || result.ready);
	assign tick.ready = !valid_s1 || advance;

	// stamp wraps modulo 2^32; zero stored stamp means no elapsed time
	assign diff = tick.time_ms - last_time_q;
	always_comb begin
		if (last_time_q == '0)
			dt = '0;
		else if (diff > {{(TIME_W-DT_W){1'b0}}, cfg.max_dt_ms})
			dt = cfg.max_dt_ms;
		else
			dt = diff[DT_W-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_time_q <= '0;
			valid_s1    <= 1'b0;
		end else begin
			if (accept)
				last_time_q <= tick.time_ms;
			if (accept)
				valid_s1 <= 1'b1;
			else if (advance)
				valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			arm_s1   <= tick.arm_request;
			level_s1 <= tick.attitude_level;
			desc_s1  <= tick.is_descending;
			alt_s1   <= tick.altitude_dm;
			dt_s1    <= dt;
		end
	end

	// ---- commit stage: mode and throttle ----
	mode_t              mode_q;
	mode_t              mode_d;
	logic [THR_W-1:0]   throttle_q;
	logic [THR_W-1:0]   throttle_d;
	logic [THR_W-1:0]   off_fix;
	logic [THR_W-1:0]   target;
	logic [PROD_W-1:0]  prod;
	logic [SUM_W-1:0]   sum;
	logic               trigger;

	assign off_fix = {cfg.pulse_off_us, {FRAC_BITS{1'b0}}};
	assign target  = {cfg.pulse_run_us, {FRAC_BITS{1'b0}}};
	assign prod    = cfg.ramp_step_q16 * dt_s1;
	assign sum     = {{(SUM_W-THR_W){1'b0}}, throttle_q} + {{(SUM_W-PROD_W){1'b0}}, prod};
	assign trigger = level_s1 && desc_s1 && ($signed(alt_s1) <= $signed(cfg.alt_trigger_dm));

	// next mode
	always_comb begin
		if (!arm_s1) begin
			mode_d = MODE_DISARMED;
		end else begin
			case (mode_q)
				MODE_DISARMED: mode_d = MODE_ARMED;
				MODE_ARMED:    mode_d = trigger ? MODE_MOTORS_ON : MODE_ARMED;
				default:       mode_d = mode_q;
			endcase
		end
	end

	// throttle update
	always_comb begin
		throttle_d = throttle_q;
		if (!arm_s1) begin
			throttle_d = off_fix;
		end else begin
			case (mode_q)
				MODE_DISARMED: throttle_d = off_fix;
				MODE_ARMED:    throttle_d = throttle_q;
				default: begin
					// ramp only while level and below target, never lowered
					if (level_s1 && (throttle_q < target)) begin
						if (sum > {{(SUM_W-THR_W){1'b0}}, target})
							throttle_d = target;
						else
							throttle_d = sum[THR_W-1:0];
					end
				end
			endcase
		end
	end

	// ---- result register ----
	logic               out_valid_q;
	logic [PULSE_W-1:0] pulse_q;
	mode_t              mode_out_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q      <= MODE_DISARMED;
			throttle_q  <= {PULSE_OFF_RST, {FRAC_BITS{1'b0}}};
			out_valid_q <= 1'b0;
		end else begin
			if (advance) begin
				mode_q     <= mode_d;
				throttle_q <= throttle_d;
			end
			if (advance)
				out_valid_q <= 1'b1;
			else if (result.ready)
				out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			pulse_q    <= throttle_d[THR_W-1:FRAC_BITS];
			mode_out_q <= mode_d;
		end
	end

	assign result.valid    = out_valid_q;
	assign result.pulse_us = pulse_q;
	assign result.mode     = mode_out_q;

endmodule

/* hw/rtl/mat_checker.sv */
// Port-level checker of the motor arm and throttle ramp block, with its bind.
`timescale 1ns / 1ps
`include "motor_arm_and_throttle_ramp_assert.svh"
module mat_checker import mat_pkg::*; (
	input logic               clk,
	input logic               arst_n,
	input logic               tick_valid,
	input logic               tick_ready,
	input logic               res_valid,
	input logic               res_ready,
	input logic [PULSE_W-1:0] res_pulse,
	input logic [MODE_W-1:0]  res_mode
);

	// stalled result keeps its payload
	`MAT_ASSERT_NEXT(a_res_hold, clk, arst_n, res_valid && !res_ready, res_valid && $stable(res_pulse) && $stable(res_mode))

	// backpressure on tick only comes from a stalled result
	`MAT_ASSERT_IMPL(a_tick_stall, clk, arst_n, !tick_ready, res_valid && !res_ready)

	// reported mode is one of the three defined codes
	`MAT_ASSERT_IMPL(a_mode_code, clk, arst_n, res_valid, res_mode == MODE_DISARMED || res_mode == MODE_ARMED || res_mode == MODE_MOTORS_ON)

	// an accepted tick with a free sink shows up as a result
	`MAT_ASSERT_NEXT(a_latency, clk, arst_n, tick_valid && tick_ready && !res_valid, ##1 (res_valid || !res_ready || $past(res_ready)))

endmodule

bind motor_arm_and_throttle_ramp mat_checker u_mat_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.tick_valid (tick.valid),
	.tick_ready (tick.ready),
	.res_valid  (result.valid),
	.res_ready  (result.ready),
	.res_pulse  (result.pulse_us),
	.res_mode   (result.mode)
);
